// ----- hdl/ezr_pkg.sv -----
// Package with shared types, constants and arithmetic helpers for the Euler-to-matrix block.
package ezr_pkg;

  localparam int TrigSteps   = 16;
  localparam int AtanEntries = 24;
  localparam int CordicIters = (TrigSteps > AtanEntries) ? AtanEntries : TrigSteps;

  localparam int AngW = 16;
  localparam int OutW = 16;
  localparam int CrdW = 34;

  localparam logic signed [AngW-1:0] PiQ13     = 16'sd25736;
  localparam logic signed [AngW:0]   TwoPiQ13  = 17'sd51472;
  localparam logic signed [AngW-1:0] HalfPiQ13 = 16'sd12868;
  localparam logic signed [CrdW-1:0] GainQ30   = 34'sd652032874;
  localparam logic signed [OutW-1:0] OneQ14    = 16'sd16384;

  typedef logic signed [AngW-1:0] ang_t;
  typedef logic signed [OutW-1:0] q14_t;
  typedef logic signed [CrdW-1:0] crd_t;

  typedef struct packed {
    ang_t roll_angle;
    ang_t pitch_angle;
    ang_t yaw_angle;
  } angles_t;

  typedef struct packed {
    q14_t r00; q14_t r01; q14_t r02;
    q14_t r10; q14_t r11; q14_t r12;
    q14_t r20; q14_t r21; q14_t r22;
  } matrix_t;

  typedef struct packed {
    q14_t s;
    q14_t c;
  } sincos_t;

  typedef struct packed {
    crd_t x;
    crd_t y;
    crd_t z;
    logic neg;
  } crd_state_t;

  function automatic crd_t atan_q30(input int i);
    case (i)
      0:  atan_q30 = 34'sh03243F6A8;
      1:  atan_q30 = 34'sh01DAC6705;
      2:  atan_q30 = 34'sh00FADBAFC;
      3:  atan_q30 = 34'sh007F56EA6;
      4:  atan_q30 = 34'sh003FEAB76;
      5:  atan_q30 = 34'sh001FFD55B;
      6:  atan_q30 = 34'sh000FFFAAA;
      7:  atan_q30 = 34'sh0007FFF55;
      8:  atan_q30 = 34'sh0003FFFEA;
      9:  atan_q30 = 34'sh0001FFFFD;
      10: atan_q30 = 34'sh0000FFFFF;
      11: atan_q30 = 34'sh00007FFFF;
      12: atan_q30 = 34'sh00003FFFF;
      13: atan_q30 = 34'sh00001FFFF;
      14: atan_q30 = 34'sh00000FFFF;
      15: atan_q30 = 34'sh000007FFF;
      16: atan_q30 = 34'sh000003FFF;
      17: atan_q30 = 34'sh000001FFF;
      18: atan_q30 = 34'sh000000FFF;
      19: atan_q30 = 34'sh0000007FF;
      20: atan_q30 = 34'sh0000003FF;
      21: atan_q30 = 34'sh0000001FF;
      22: atan_q30 = 34'sh0000000FF;
      23: atan_q30 = 34'sh00000007F;
      default: atan_q30 = '0;
    endcase
  endfunction

  // Clamp a wide signed value to the Q1.14 range of plus or minus one.
  function automatic q14_t sat_q14(input logic signed [47:0] v);
    if (v > 48'sd16384) sat_q14 = OneQ14;
    else if (v < -48'sd16384) sat_q14 = -OneQ14;
    else sat_q14 = v[OutW-1:0];
  endfunction

endpackage

// ----- hdl/ezr_stream_if.sv -----
// Valid/ready stream interface carrying one payload beat.
interface ezr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/euler_zyx_to_rotation_matrix_top.sv -----
// Top level: Z-Y-X Euler angles to rotation matrix, fully pipelined.
//
// Channels: in_if carries roll, pitch and yaw in Q2.13 radians; out_if carries
// the nine matrix entries in Q1.14. Both use valid/ready; a beat moves when
// both are high.
// Throughput is one beat per cycle while the receiver does not stall. The stages
// are one register for the angle fold, one per CORDIC iteration, one for rounding,
// then three for the matrix products and sums.
// The whole pipeline advances as one unit: when the receiver holds ready low
// with a valid result at the output, every stage holds and in_if.ready drops,
// so no beat is lost or repeated. Bubbles travel with the pipeline and are
// not squeezed out; a stall freezes them in place along with the data.
// Reset clears only the valid bits; the data registers need no reset.
module euler_zyx_to_rotation_matrix_top import ezr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  ezr_stream_if.sink   in_if,
  ezr_stream_if.source out_if
);

  localparam int Depth = CordicIters + 5;

  logic [Depth-1:0] vld_q;
  logic             en;
  sincos_t          sc_r, sc_p, sc_y;
  matrix_t          mat;

  assign en          = !vld_q[Depth-1] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_if.valid};
    end
  end

  ezr_cordic u_roll  (.clk_i, .en_i(en), .angle_i(in_if.data.roll_angle),  .sc_o(sc_r));
  ezr_cordic u_pitch (.clk_i, .en_i(en), .angle_i(in_if.data.pitch_angle), .sc_o(sc_p));
  ezr_cordic u_yaw   (.clk_i, .en_i(en), .angle_i(in_if.data.yaw_angle),   .sc_o(sc_y));

  ezr_matrix u_matrix (
    .clk_i,
    .en_i    (en),
    .roll_i  (sc_r),
    .pitch_i (sc_p),
    .yaw_i   (sc_y),
    .mat_o   (mat)
  );

  assign out_if.valid = vld_q[Depth-1];
  assign out_if.data  = mat;

endmodule

// ----- hdl/ezr_cordic.sv -----
// Pipelined rotation-mode CORDIC for one angle: range fold, iterations, rounding.
module ezr_cordic import ezr_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  ang_t    angle_i,
  output sincos_t sc_o
);

  crd_state_t st_q [CordicIters+1];
  crd_state_t st_d [CordicIters+1];
  sincos_t    sc_q;

  logic signed [AngW:0] a_w;
  logic signed [AngW:0] a_f;
  logic                 neg;

  always_comb begin
    a_w = AngW'(0) + 17'(angle_i);
    if (a_w > 17'(PiQ13)) a_w = a_w - TwoPiQ13;
    if (a_w < -17'(PiQ13)) a_w = a_w + TwoPiQ13;
    neg = 1'b0;
    a_f = a_w;
    if (a_w > 17'(HalfPiQ13)) begin
      a_f = a_w - 17'(PiQ13);
      neg = 1'b1;
    end else if (a_w < -17'(HalfPiQ13)) begin
      a_f = a_w + 17'(PiQ13);
      neg = 1'b1;
    end
    st_d[0].x   = GainQ30;
    st_d[0].y   = '0;
    st_d[0].z   = {a_f, 17'd0};
    st_d[0].neg = neg;
  end

  for (genvar i = 0; i < CordicIters; i++) begin : g_iter
    always_comb begin
      st_d[i+1].neg = st_q[i].neg;
      if (!st_q[i].z[CrdW-1]) begin
        st_d[i+1].x = st_q[i].x - (st_q[i].y >>> i);
        st_d[i+1].y = st_q[i].y + (st_q[i].x >>> i);
        st_d[i+1].z = st_q[i].z - atan_q30(i);
      end else begin
        st_d[i+1].x = st_q[i].x + (st_q[i].y >>> i);
        st_d[i+1].y = st_q[i].y - (st_q[i].x >>> i);
        st_d[i+1].z = st_q[i].z + atan_q30(i);
      end
    end
  end

  for (genvar i = 0; i <= CordicIters; i++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (en_i) st_q[i] <= st_d[i];
    end
  end

  crd_t xf, yf;
  logic signed [47:0] xr, yr;

  always_comb begin
    xf = st_q[CordicIters].neg ? -st_q[CordicIters].x : st_q[CordicIters].x;
    yf = st_q[CordicIters].neg ? -st_q[CordicIters].y : st_q[CordicIters].y;
    xr = 48'((48'(xf) + 48'sd32768) >>> 16);
    yr = 48'((48'(yf) + 48'sd32768) >>> 16);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_q.c <= sat_q14(xr);
      sc_q.s <= sat_q14(yr);
    end
  end

  assign sc_o = sc_q;

endmodule

// ----- hdl/ezr_matrix.sv -----
// Three-stage product and rounding pipeline that forms the nine matrix entries.
module ezr_matrix import ezr_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  sincos_t roll_i,
  input  sincos_t pitch_i,
  input  sincos_t yaw_i,
  output matrix_t mat_o
);

  typedef logic signed [31:0] p2_t;
  typedef logic signed [47:0] p3_t;

  // Stage A: pairwise products in Q28.
  p2_t cycp_q, sycp_q, cpsr_q, cpcr_q, cysp_q, sysp_q;
  p2_t sycr_q, sysr_q, cycr_q, cysr_q;
  q14_t sr_q, cr_q, sp_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cycp_q <= yaw_i.c * pitch_i.c;
      sycp_q <= yaw_i.s * pitch_i.c;
      cpsr_q <= pitch_i.c * roll_i.s;
      cpcr_q <= pitch_i.c * roll_i.c;
      cysp_q <= yaw_i.c * pitch_i.s;
      sysp_q <= yaw_i.s * pitch_i.s;
      sycr_q <= yaw_i.s * roll_i.c;
      sysr_q <= yaw_i.s * roll_i.s;
      cycr_q <= yaw_i.c * roll_i.c;
      cysr_q <= yaw_i.c * roll_i.s;
      sr_q   <= roll_i.s;
      cr_q   <= roll_i.c;
      sp_q   <= pitch_i.s;
    end
  end

  // Stage B: third factor; two-factor terms for the sums move to Q42, the rest round to Q14.
  p3_t t01a_q, t02a_q, t11a_q, t12a_q;
  p3_t t01b_q, t02b_q, t11b_q, t12b_q;
  q14_t r00_b, r10_b, r20_b, r21_b, r22_b;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t01a_q <= 48'(cysp_q) * 48'(sr_q);
      t02a_q <= 48'(cysp_q) * 48'(cr_q);
      t11a_q <= 48'(sysp_q) * 48'(sr_q);
      t12a_q <= 48'(sysp_q) * 48'(cr_q);
      t01b_q <= 48'(sycr_q) <<< 14;
      t02b_q <= 48'(sysr_q) <<< 14;
      t11b_q <= 48'(cycr_q) <<< 14;
      t12b_q <= 48'(cysr_q) <<< 14;
      r00_b  <= sat_q14(48'((48'(cycp_q) + 48'sd8192) >>> 14));
      r10_b  <= sat_q14(48'((48'(sycp_q) + 48'sd8192) >>> 14));
      r21_b  <= sat_q14(48'((48'(cpsr_q) + 48'sd8192) >>> 14));
      r22_b  <= sat_q14(48'((48'(cpcr_q) + 48'sd8192) >>> 14));
      r20_b  <= sat_q14(-48'(sp_q));
    end
  end

  // Stage C: sum, round from Q42 and clamp.
  localparam p3_t RndQ42 = 48'sd134217728;
  matrix_t mat_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mat_q.r00 <= r00_b;
      mat_q.r10 <= r10_b;
      mat_q.r20 <= r20_b;
      mat_q.r21 <= r21_b;
      mat_q.r22 <= r22_b;
      mat_q.r01 <= sat_q14((t01a_q - t01b_q + RndQ42) >>> 28);
      mat_q.r02 <= sat_q14((t02a_q + t02b_q + RndQ42) >>> 28);
      mat_q.r11 <= sat_q14((t11a_q + t11b_q + RndQ42) >>> 28);
      mat_q.r12 <= sat_q14((t12a_q - t12b_q + RndQ42) >>> 28);
    end
  end

  assign mat_o = mat_q;

endmodule

// ----- hdl/ezr_checker.sv -----
// Port-level checker for the Euler-to-matrix top level, with its bind.
module ezr_checker import ezr_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input matrix_t out_data
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_r20_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.r20 <= OneQ14 && out_data.r20 >= -OneQ14)
    else $error("entry out of range");

endmodule

bind euler_zyx_to_rotation_matrix_top ezr_checker u_ezr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);
